[rtl/stkc_pkg.sv]
// shared types and constants of the stack calculator
package stkc_pkg;

  localparam int DEPTH = 16;
  localparam int WIDTH = 32;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int CNTW  = $clog2(WIDTH + 1);
  localparam int KW    = 4;
  localparam int SW    = 2;

  typedef enum logic [KW-1:0] {
    K_PUSH  = 4'd0,
    K_POP   = 4'd1,
    K_DROP  = 4'd2,
    K_SWAP  = 4'd3,
    K_ADD   = 4'd4,
    K_SUB   = 4'd5,
    K_MUL   = 4'd6,
    K_DIV   = 4'd7,
    K_MOD   = 4'd8,
    K_POW   = 4'd9,
    K_CLEAR = 4'd10
  } kind_t;

  typedef enum logic [SW-1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_FULL  = 2'd2,
    ST_DIVZ  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_POP,
    CS_RDA,
    CS_RDB,
    CS_SWAP,
    CS_ALU
  } ctl_state_t;

  typedef enum logic [1:0] {
    AS_IDLE,
    AS_POW,
    AS_DIV,
    AS_DONE
  } alu_state_t;

  typedef enum logic [1:0] {
    AOP_MUL,
    AOP_DIV,
    AOP_MOD,
    AOP_POW
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

endpackage

[rtl/stkc_ram.sv]
// stack memory: one write port, one registered read port
module stkc_ram #(
  parameter int AW = 4,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/stkc_alu.sv]
// iterative unit for multiply, power (square and multiply) and signed divide / modulo
module stkc_alu (
  input  logic                        clk,
  input  logic                        rst_n,
  input  stkc_pkg::alu_req_t          req,
  input  logic [stkc_pkg::WIDTH-1:0]  opa,
  input  logic [stkc_pkg::WIDTH-1:0]  opb,
  output logic                        done,
  output logic [stkc_pkg::WIDTH-1:0]  result
);
  import stkc_pkg::*;

  alu_state_t       state_r, state_nxt;
  alu_op_t          op_r, op_nxt;
  logic [WIDTH-1:0] acc_r, acc_nxt;
  logic [WIDTH-1:0] base_r, base_nxt;
  logic [WIDTH-1:0] ex_r, ex_nxt;
  logic [WIDTH-1:0] rem_r, rem_nxt;
  logic [CNTW-1:0]  cnt_r, cnt_nxt;
  logic             negq_r, negq_nxt;
  logic             negr_r, negr_nxt;
  logic [WIDTH-1:0] res_r, res_nxt;

  logic [2*WIDTH-1:0] prod_ab;
  logic [2*WIDTH-1:0] prod_bb;
  logic [WIDTH:0]     trial;
  logic [WIDTH:0]     diff;
  logic [WIDTH-1:0]   mag_a;
  logic [WIDTH-1:0]   mag_b;

  assign prod_ab = acc_r * base_r;
  assign prod_bb = base_r * base_r;
  assign trial   = {rem_r, acc_r[WIDTH-1]};
  assign diff    = trial - {1'b0, base_r};
  assign mag_a   = opa[WIDTH-1] ? (~opa + WIDTH'(1)) : opa;
  assign mag_b   = opb[WIDTH-1] ? (~opb + WIDTH'(1)) : opb;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= AS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    acc_r  <= acc_nxt;
    base_r <= base_nxt;
    ex_r   <= ex_nxt;
    rem_r  <= rem_nxt;
    cnt_r  <= cnt_nxt;
    negq_r <= negq_nxt;
    negr_r <= negr_nxt;
    res_r  <= res_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    acc_nxt   = acc_r;
    base_nxt  = base_r;
    ex_nxt    = ex_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    negq_nxt  = negq_r;
    negr_nxt  = negr_r;
    res_nxt   = res_r;
    done      = 1'b0;
    unique case (state_r)
      AS_IDLE: begin
        if (req.start) begin
          op_nxt = req.op;
          unique case (req.op)
            AOP_MUL: begin
              acc_nxt   = opa;
              base_nxt  = opb;
              ex_nxt    = WIDTH'(1);
              state_nxt = AS_POW;
            end
            AOP_POW: begin
              acc_nxt   = WIDTH'(1);
              base_nxt  = opb;
              ex_nxt    = opa[WIDTH-1] ? '0 : opa;
              state_nxt = AS_POW;
            end
            AOP_DIV, AOP_MOD: begin
              acc_nxt   = mag_a;
              base_nxt  = mag_b;
              rem_nxt   = '0;
              cnt_nxt   = CNTW'(WIDTH);
              negq_nxt  = opa[WIDTH-1] ^ opb[WIDTH-1];
              negr_nxt  = opa[WIDTH-1];
              state_nxt = AS_DIV;
            end
          endcase
        end
      end
      AS_POW: begin
        if (ex_r == '0) begin
          res_nxt   = acc_r;
          state_nxt = AS_DONE;
        end else begin
          if (ex_r[0]) begin
            acc_nxt = prod_ab[WIDTH-1:0];
          end
          base_nxt = prod_bb[WIDTH-1:0];
          ex_nxt   = ex_r >> 1;
        end
      end
      AS_DIV: begin
        if (cnt_r == '0) begin
          if (op_r == AOP_DIV) begin
            res_nxt = negq_r ? (~acc_r + WIDTH'(1)) : acc_r;
          end else begin
            res_nxt = negr_r ? (~rem_r + WIDTH'(1)) : rem_r;
          end
          state_nxt = AS_DONE;
        end else begin
          if (!diff[WIDTH]) begin
            rem_nxt = diff[WIDTH-1:0];
            acc_nxt = {acc_r[WIDTH-2:0], 1'b1};
          end else begin
            rem_nxt = trial[WIDTH-1:0];
            acc_nxt = {acc_r[WIDTH-2:0], 1'b0};
          end
          cnt_nxt = cnt_r - CNTW'(1);
        end
      end
      AS_DONE: begin
        done      = 1'b1;
        state_nxt = AS_IDLE;
      end
    endcase
  end

  assign result = res_r;

endmodule

[rtl/stack_calculator_core.sv]
// stack calculator top level: command sequencer around the stack memory and arithmetic unit
//
// usage: drive in_kind and in_value and raise start; a command word is taken at
// a rising edge where start is high and busy is low. every command word gives
// exactly one result word on out_result, out_status and out_depth, shown for
// one cycle with out_valid high, starting the cycle after the command ends.
// push, drop, clear and unused kinds leave busy low, so they may follow each
// other on every cycle. add and sub make two memory reads at one per cycle
// through the single read port, with the write-back when the second read's
// data arrives; swap makes two reads, then two writes. div and mod use the
// divider, which resolves one quotient bit per cycle; pow takes one
// square-and-multiply step per exponent bit up to the highest set bit.
// errors (underflow, full, divide by zero) leave the stack unchanged and give
// a zero result word. reset empties the stack at once: no clearing pass.
// the receiver cannot stall: a result word is gone after its one cycle.
module stack_calculator_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [stkc_pkg::KW-1:0]            in_kind,
  input  logic signed [stkc_pkg::WIDTH-1:0]  in_value,
  output logic                               out_valid,
  output logic signed [stkc_pkg::WIDTH-1:0]  out_result,
  output logic [stkc_pkg::SW-1:0]            out_status,
  output logic [stkc_pkg::CW-1:0]            out_depth
);
  import stkc_pkg::*;

  ctl_state_t       state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [KW-1:0]    kind_r, kind_nxt;
  logic [WIDTH-1:0] a_r, a_nxt;
  logic             ov_r, ov_nxt;
  logic [WIDTH-1:0] res_r, res_nxt;
  status_t          stat_r, stat_nxt;
  logic [CW-1:0]    depth_r;

  logic             we;
  logic [AW-1:0]    waddr;
  logic [WIDTH-1:0] wdata;
  logic             re;
  logic [AW-1:0]    raddr;
  logic [WIDTH-1:0] rd_data;
  logic [CW-1:0]    cm1;
  logic [CW-1:0]    cm2;
  logic [WIDTH-1:0] sum;
  logic [WIDTH-1:0] dif;

  alu_req_t         alu_req;
  logic             alu_done;
  logic [WIDTH-1:0] alu_res;

  assign cm1 = count_r - CW'(1);
  assign cm2 = count_r - CW'(2);
  assign sum = a_r + rd_data;
  assign dif = a_r - rd_data;

  stkc_ram #(
    .AW (AW),
    .DW (WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rd_data)
  );

  stkc_alu u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (alu_req),
    .opa    (a_r),
    .opb    (rd_data),
    .done   (alu_done),
    .result (alu_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
      count_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    a_r     <= a_nxt;
    res_r   <= res_nxt;
    stat_r  <= stat_nxt;
    depth_r <= count_nxt;
  end

  // accesses are sequenced so a read never meets a write to the same entry
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    kind_nxt      = kind_r;
    a_nxt         = a_r;
    ov_nxt        = 1'b0;
    res_nxt       = '0;
    stat_nxt      = ST_OK;
    we            = 1'b0;
    waddr         = cm2[AW-1:0];
    wdata         = rd_data;
    re            = 1'b0;
    raddr         = cm1[AW-1:0];
    alu_req.start = 1'b0;
    alu_req.op    = AOP_MUL;
    unique case (state_r)
      CS_IDLE: begin
        if (start) begin
          kind_nxt = in_kind;
          unique case (in_kind)
            K_PUSH: begin
              ov_nxt = 1'b1;
              if (count_r == CW'(DEPTH)) begin
                stat_nxt = ST_FULL;
              end else begin
                we        = 1'b1;
                waddr     = count_r[AW-1:0];
                wdata     = in_value;
                count_nxt = count_r + CW'(1);
              end
            end
            K_POP: begin
              if (count_r == '0) begin
                ov_nxt   = 1'b1;
                stat_nxt = ST_UNDER;
              end else begin
                re        = 1'b1;
                count_nxt = cm1;
                state_nxt = CS_POP;
              end
            end
            K_DROP: begin
              ov_nxt = 1'b1;
              if (count_r == '0) begin
                stat_nxt = ST_UNDER;
              end else begin
                count_nxt = cm1;
              end
            end
            K_SWAP, K_ADD, K_SUB, K_MUL, K_DIV, K_MOD, K_POW: begin
              if (count_r < CW'(2)) begin
                ov_nxt   = 1'b1;
                stat_nxt = ST_UNDER;
              end else begin
                re        = 1'b1;
                state_nxt = CS_RDA;
              end
            end
            K_CLEAR: begin
              ov_nxt    = 1'b1;
              count_nxt = '0;
            end
            default: begin
              ov_nxt = 1'b1;
            end
          endcase
        end
      end
      CS_POP: begin
        ov_nxt    = 1'b1;
        res_nxt   = rd_data;
        state_nxt = CS_IDLE;
      end
      CS_RDA: begin
        a_nxt     = rd_data;
        re        = 1'b1;
        raddr     = cm2[AW-1:0];
        state_nxt = CS_RDB;
      end
      CS_RDB: begin
        state_nxt = CS_IDLE;
        unique case (kind_r)
          K_SWAP: begin
            we        = 1'b1;
            waddr     = cm1[AW-1:0];
            wdata     = rd_data;
            state_nxt = CS_SWAP;
          end
          K_ADD, K_SUB: begin
            we        = 1'b1;
            wdata     = (kind_r == K_ADD) ? sum : dif;
            count_nxt = cm1;
            ov_nxt    = 1'b1;
            res_nxt   = wdata;
          end
          K_DIV, K_MOD: begin
            if (rd_data == '0) begin
              ov_nxt   = 1'b1;
              stat_nxt = ST_DIVZ;
            end else begin
              alu_req.start = 1'b1;
              alu_req.op    = (kind_r == K_DIV) ? AOP_DIV : AOP_MOD;
              state_nxt     = CS_ALU;
            end
          end
          K_MUL, K_POW: begin
            alu_req.start = 1'b1;
            alu_req.op    = (kind_r == K_MUL) ? AOP_MUL : AOP_POW;
            state_nxt     = CS_ALU;
          end
          default: begin
            ov_nxt = 1'b1;
          end
        endcase
      end
      CS_SWAP: begin
        we        = 1'b1;
        wdata     = a_r;
        ov_nxt    = 1'b1;
        state_nxt = CS_IDLE;
      end
      CS_ALU: begin
        if (alu_done) begin
          we        = 1'b1;
          wdata     = alu_res;
          count_nxt = cm1;
          ov_nxt    = 1'b1;
          res_nxt   = alu_res;
          state_nxt = CS_IDLE;
        end
      end
    endcase
  end

  assign busy       = (state_r != CS_IDLE);
  assign out_valid  = ov_r;
  assign out_result = res_r;
  assign out_status = stat_r;
  assign out_depth  = depth_r;

endmodule

[rtl/stkc_checker.sv]
// port-level assertions for the stack calculator, bound to the top level
module stkc_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               start,
  input logic                               busy,
  input logic [stkc_pkg::KW-1:0]            in_kind,
  input logic                               out_valid,
  input logic signed [stkc_pkg::WIDTH-1:0]  out_result,
  input logic [stkc_pkg::SW-1:0]            out_status,
  input logic [stkc_pkg::CW-1:0]            out_depth
);
  import stkc_pkg::*;

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_depth <= CW'(DEPTH))
    else $error("depth beyond stack size");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> out_result == '0)
    else $error("error word with nonzero result");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_kind == K_CLEAR) |=> (out_valid && out_depth == '0 && !busy))
    else $error("clear did not empty the stack");

  a_push: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_kind == K_PUSH) |=>
      (out_valid && out_result == '0 && (out_status == ST_OK || out_status == ST_FULL)))
    else $error("push word not answered next cycle");

endmodule

bind stack_calculator_core stkc_checker u_stkc_checker (.*);
